[design/agc_pkg.sv]
package agc_pkg;

	localparam int SMP_W  = 16;
	localparam int GAIN_W = 17;
	localparam int PT_W   = 15;
	localparam int NUM_W  = 30;
	localparam int MUL_W  = 49;

	localparam logic [15:0] RST_DC_ALPHA     = 16'd32604;
	localparam logic [14:0] RST_PEAK_TARGET  = 15'd24000;
	localparam logic [16:0] RST_GAIN_FLOOR   = 17'd8192;
	localparam logic [16:0] RST_GAIN_CEILING = 17'd65536;
	localparam logic [3:0]  RST_ATTACK       = 4'd1;
	localparam logic [3:0]  RST_RELEASE      = 4'd4;
	localparam logic [16:0] GAIN_UNITY       = 17'd32768;
	localparam logic [15:0] ALPHA_MAX        = 16'd32768;

	localparam logic [2:0] REG_DC_ALPHA     = 3'd0;
	localparam logic [2:0] REG_PEAK_TARGET  = 3'd1;
	localparam logic [2:0] REG_GAIN_FLOOR   = 3'd2;
	localparam logic [2:0] REG_GAIN_CEILING = 3'd3;
	localparam logic [2:0] REG_ATTACK       = 3'd4;
	localparam logic [2:0] REG_RELEASE      = 3'd5;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_in;
		logic                    block_end;
		logic                    mute;
	} agc_in_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_out;
		logic                    run_end;
		logic                    status;
	} agc_out_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} agc_div_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SMOOTH,
		ST_RD,
		ST_MUL1,
		ST_FILT,
		ST_MUL2,
		ST_LIM,
		ST_EMIT
	} agc_state_t;

endpackage

[design/agc_ram.sv]
module agc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/agc_div.sv]
module agc_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [agc_pkg::NUM_W-1:0]            num,
	input  logic [agc_pkg::SMP_W-1:0]            den,
	output agc_pkg::agc_div_res_t                res
);
	import agc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [SMP_W-1:0] rem_q;
	logic [SMP_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SMP_W:0]   trial;
	logic             fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? SMP_W'(trial - {1'b0, den_q}) : trial[SMP_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = num_q;

endmodule

[design/block_agc_dc_blocker_limiter.sv]
// input: one sample per cycle while idle; the block end or the sample that fills the store
// starts processing, during which no input is taken
// processing: serial division for the gain target unless the peak is zero, then smoothing;
// per buffered sample: read, multiply, filter, multiply (shared multiplier), limit, emit, plus output wait time
// reset clears registers to defaults, gain to unity, fill count, peak and filter state
module block_agc_dc_blocker_limiter #(
	parameter int BLOCK_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                smp_valid,
	output logic                smp_ready,
	input  agc_pkg::agc_in_t    smp_data,
	output logic                res_valid,
	input  logic                res_ready,
	output agc_pkg::agc_out_t   res_data
);
	import agc_pkg::*;

	localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
	localparam int CW = $clog2(BLOCK_DEPTH + 1);

	logic [15:0]       dc_alpha_q;
	logic [PT_W-1:0]   peak_target_q;
	logic [GAIN_W-1:0] gain_floor_q;
	logic [GAIN_W-1:0] gain_ceiling_q;
	logic [3:0]        attack_q;
	logic [3:0]        release_q;

	agc_state_t state_q, state_nx;

	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           idx_q;
	logic [SMP_W-1:0]        peak_q;
	logic [GAIN_W-1:0]       gain_q;
	logic signed [SMP_W-1:0] prev_in_q;
	logic signed [31:0]      prev_f_q;
	logic signed [31:0]      y_q;
	logic signed [MUL_W-1:0] mul_q;
	logic                    mute_q;
	agc_out_t                out_q;

	logic              wr_en;
	logic [2:0]        reg_idx;
	logic              cfg_ok;
	logic              active;
	logic              accept;
	logic              blk_done;
	logic [SMP_W-1:0]  mag;
	logic [SMP_W-1:0]  peak_nx;
	logic [CW-1:0]     fill_nx;
	logic              div_start;
	logic              last_idx;
	agc_div_res_t      div_res;
	logic [SMP_W-1:0]  rd_data;

	logic [GAIN_W-1:0]       tgt;
	logic signed [GAIN_W:0]  gdiff;
	logic signed [GAIN_W:0]  gstep;
	logic [3:0]              shamt;

	logic signed [31:0]      mul_a;
	logic [GAIN_W-1:0]       mul_b;
	logic signed [33:0]      fb;
	logic signed [34:0]      ysum;
	logic signed [31:0]      ysat;
	logic signed [34:0]      scaled;
	logic signed [34:0]      lim;
	logic signed [SMP_W-1:0] lim_out;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_alpha_q     <= RST_DC_ALPHA;
			peak_target_q  <= RST_PEAK_TARGET;
			gain_floor_q   <= RST_GAIN_FLOOR;
			gain_ceiling_q <= RST_GAIN_CEILING;
			attack_q       <= RST_ATTACK;
			release_q      <= RST_RELEASE;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DC_ALPHA:     dc_alpha_q     <= pwdata[15:0];
				REG_PEAK_TARGET:  peak_target_q  <= pwdata[PT_W-1:0];
				REG_GAIN_FLOOR:   gain_floor_q   <= pwdata[GAIN_W-1:0];
				REG_GAIN_CEILING: gain_ceiling_q <= pwdata[GAIN_W-1:0];
				REG_ATTACK:       attack_q       <= pwdata[3:0];
				REG_RELEASE:      release_q      <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DC_ALPHA:     prdata = {16'd0, dc_alpha_q};
			REG_PEAK_TARGET:  prdata = {17'd0, peak_target_q};
			REG_GAIN_FLOOR:   prdata = {15'd0, gain_floor_q};
			REG_GAIN_CEILING: prdata = {15'd0, gain_ceiling_q};
			REG_ATTACK:       prdata = {28'd0, attack_q};
			REG_RELEASE:      prdata = {28'd0, release_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg_ok = (dc_alpha_q <= ALPHA_MAX) && (peak_target_q != '0)
		&& (gain_ceiling_q >= gain_floor_q);
	assign active = cfg_ok && !mute_q;

	// input side
	assign accept   = smp_valid && smp_ready;
	assign mag      = smp_data.sample_in[SMP_W-1] ? SMP_W'(-smp_data.sample_in)
		: smp_data.sample_in;
	assign peak_nx  = (mag > peak_q) ? mag : peak_q;
	assign fill_nx  = fill_q + 1'b1;
	assign blk_done = smp_data.block_end || (fill_nx == CW'(BLOCK_DEPTH));
	assign last_idx = (CW'(idx_q + 1'b1) == fill_q);

	agc_ram #(.WIDTH(SMP_W), .DEPTH(BLOCK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (fill_q[AW-1:0]),
		.wdata (smp_data.sample_in),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	agc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({peak_target_q, 15'd0}),
		.den    (peak_nx),
		.res    (div_res)
	);

	// gain target and smoothing
	always_comb begin
		if (peak_q == '0) begin
			tgt = gain_ceiling_q;
		end else if (div_res.quot < NUM_W'(gain_floor_q)) begin
			tgt = gain_floor_q;
		end else if (div_res.quot > NUM_W'(gain_ceiling_q)) begin
			tgt = gain_ceiling_q;
		end else begin
			tgt = div_res.quot[GAIN_W-1:0];
		end
	end

	assign shamt = (tgt < gain_q) ? attack_q : release_q;
	assign gdiff = $signed({1'b0, tgt}) - $signed({1'b0, gain_q});
	// arithmetic shift floors, matching the rounding of a falling step
	assign gstep = gdiff >>> shamt;

	// shared multiplier operands
	assign mul_a = (state_q == ST_MUL2) ? y_q : prev_f_q;
	assign mul_b = (state_q == ST_MUL2) ? gain_q : GAIN_W'(dc_alpha_q);

	// truncating divide by 32768 on the product
	assign fb   = mul_q[MUL_W-1] ? 34'((mul_q + MUL_W'(32767)) >>> 15) : 34'(mul_q >>> 15);
	assign ysum = 35'($signed(rd_data)) - 35'(prev_in_q) + 35'(fb);
	always_comb begin
		if (ysum > 35'sd2147483647) begin
			ysat = 32'sh7fffffff;
		end else if (ysum < -35'sd2147483648) begin
			ysat = 32'sh80000000;
		end else begin
			ysat = ysum[31:0];
		end
	end

	assign scaled = fb[33] ? 35'sd0 + fb : 35'(fb);
	assign lim    = 35'($signed({1'b0, peak_target_q}));
	always_comb begin
		if (scaled > lim) begin
			lim_out = SMP_W'(lim);
		end else if (scaled < -lim) begin
			lim_out = SMP_W'(-lim);
		end else begin
			lim_out = scaled[SMP_W-1:0];
		end
	end

	// sequencer
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:   if (accept && blk_done) state_nx = (peak_nx == '0) ? ST_SMOOTH : ST_DIV;
			ST_DIV:    if (div_res.done) state_nx = ST_SMOOTH;
			ST_SMOOTH: state_nx = ST_RD;
			ST_RD:     state_nx = ST_MUL1;
			ST_MUL1:   state_nx = ST_FILT;
			ST_FILT:   state_nx = ST_MUL2;
			ST_MUL2:   state_nx = ST_LIM;
			ST_LIM:    state_nx = ST_EMIT;
			ST_EMIT:   if (res_ready) state_nx = last_idx ? ST_IDLE : ST_RD;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		smp_ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_EMIT);
		div_start = accept && blk_done && (peak_nx != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			idx_q     <= '0;
			peak_q    <= '0;
			gain_q    <= GAIN_UNITY;
			prev_in_q <= '0;
			prev_f_q  <= '0;
			mute_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				fill_q <= fill_nx;
				peak_q <= peak_nx;
				mute_q <= smp_data.mute;
				idx_q  <= '0;
			end
			if (state_q == ST_SMOOTH && cfg_ok) begin
				gain_q <= GAIN_W'($signed({1'b0, gain_q}) + gstep);
			end
			if (state_q == ST_FILT && active) begin
				prev_in_q <= rd_data;
				prev_f_q  <= ysat;
			end
			if (state_q == ST_EMIT && res_ready) begin
				idx_q <= idx_q + 1'b1;
				if (last_idx) begin
					fill_q <= '0;
					peak_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL1 || state_q == ST_MUL2) begin
			mul_q <= mul_a * $signed({1'b0, mul_b});
		end
		if (state_q == ST_FILT) begin
			y_q <= ysat;
		end
		if (state_q == ST_LIM) begin
			out_q.sample_out <= active ? lim_out : '0;
			out_q.run_end    <= last_idx;
			out_q.status     <= !cfg_ok;
		end
	end

	assign res_data = out_q;

endmodule

[design/agc_chk.sv]
module agc_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              smp_ready,
	input logic              res_valid,
	input logic              res_ready,
	input agc_pkg::agc_out_t res_data
);
	import agc_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped or changed while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(smp_ready && res_valid))
		else $error("input taken while results pending");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status |-> res_data.sample_out == '0)
		else $error("nonzero sample with error status");

	a_sym_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.sample_out != 16'sh8000)
		else $error("limiter output out of range");

endmodule

bind block_agc_dc_blocker_limiter agc_chk u_agc_chk (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import agc_pkg::*;

	localparam int DEPTH = 64;
	localparam longint CYCLE_LIMIT = 2000000;

	// golden model of the agc datapath plus the queue of pending output samples
	class agc_scoreboard;
		bit [15:0] alpha;
		bit [14:0] target;
		bit [16:0] floor_g;
		bit [16:0] ceil_g;
		bit [3:0]  attack;
		bit [3:0]  release_sh;
		logic signed [15:0] stash[$];
		longint peak;
		longint gain;
		longint x_prev;
		longint y_prev;
		agc_out_t pending[$];
		int errors;
		int checked;
		int blocks;

		function void reset_state();
			alpha = RST_DC_ALPHA;
			target = RST_PEAK_TARGET;
			floor_g = RST_GAIN_FLOOR;
			ceil_g = RST_GAIN_CEILING;
			attack = RST_ATTACK;
			release_sh = RST_RELEASE;
			stash.delete();
			peak = 0;
			gain = 32768;
			x_prev = 0;
			y_prev = 0;
			pending.delete();
			errors = 0;
			checked = 0;
			blocks = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_DC_ALPHA: alpha = val[15:0];
				REG_PEAK_TARGET: target = val[14:0];
				REG_GAIN_FLOOR: floor_g = val[16:0];
				REG_GAIN_CEILING: ceil_g = val[16:0];
				REG_ATTACK: attack = val[3:0];
				REG_RELEASE: release_sh = val[3:0];
				default: ;
			endcase
		endfunction

		function longint tdiv(longint a, longint b);
			longint q;
			q = (a < 0 ? -a : a) / b;
			return (a < 0) ? -q : q;
		endfunction

		function void note_input(agc_in_t it);
			longint mag, tgt, d, y, o, fb;
			int sh;
			bit ok;
			agc_out_t r;
			stash.push_back(it.sample_in);
			mag = it.sample_in;
			if (mag < 0) mag = -mag;
			if (mag > peak) peak = mag;
			if (!it.block_end && stash.size() < DEPTH) return;
			blocks++;
			ok = alpha <= 32768 && target != 0 && ceil_g >= floor_g;
			if (ok) begin
				if (peak == 0) tgt = ceil_g;
				else begin
					tgt = (longint'(target) * 32768) / peak;
					if (tgt < floor_g) tgt = floor_g;
					if (tgt > ceil_g) tgt = ceil_g;
				end
				sh = (tgt < gain) ? attack : release_sh;
				d = tgt - gain;
				if (sh == 0) gain = tgt;
				else gain = gain + (d >>> sh); // floor toward minus infinity
			end
			foreach (stash[i]) begin
				o = 0;
				if (ok && !it.mute) begin
					fb = tdiv(longint'(alpha) * y_prev, 32768);
					y = longint'(stash[i]) - x_prev + fb;
					if (y > 64'sd2147483647) y = 64'sd2147483647;
					if (y < -64'sd2147483648) y = -64'sd2147483648;
					x_prev = stash[i];
					y_prev = y;
					o = tdiv(y * gain, 32768);
					if (o > longint'(target)) o = longint'(target);
					if (o < -longint'(target)) o = -longint'(target);
				end
				r.sample_out = o[15:0];
				r.run_end = (i == stash.size() - 1);
				r.status = !ok;
				pending.push_back(r);
			end
			stash.delete();
			peak = 0;
		endfunction

		function void check_result(agc_out_t got);
			agc_out_t want;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output transfer %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.sample_out !== want.sample_out || got.run_end !== want.run_end ||
					got.status !== want.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch #%0d: expected out=%0d end=%0b st=%0b, got out=%0d end=%0b st=%0b",
						checked, want.sample_out, want.run_end, want.status,
						got.sample_out, got.run_end, got.status);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic smp_valid, smp_ready, res_valid, res_ready;
	agc_in_t smp_data;
	agc_out_t res_data;

	agc_scoreboard sb;
	longint cycles;
	int idle_pct;
	bit hold_off;
	int hold_cycles;

	block_agc_dc_blocker_limiter i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.smp_valid(smp_valid), .smp_ready(smp_ready), .smp_data(smp_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL block_agc_dc_blocker_limiter");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && res_valid && res_ready) sb.check_result(res_data);

	// receiver side: random stalls, plus one long hold-off counted here
	always @(negedge clk) begin
		if (!arst_n) res_ready <= 0;
		else if (hold_off) begin
			res_ready <= 0;
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles >= 600) begin
				hold_off <= 0;
				hold_cycles <= 0;
			end
		end else res_ready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// valid stays high between back-to-back items and drops only while idling or draining
	task automatic send(logic signed [15:0] s, bit last, bit mute);
		agc_in_t it;
		it.sample_in = s;
		it.block_end = last;
		it.mute = mute;
		while ($urandom_range(99) < idle_pct) begin
			smp_valid <= 0;
			@(negedge clk);
		end
		smp_valid <= 1;
		smp_data <= it;
		@(posedge clk);
		while (!smp_ready) @(posedge clk);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic drain();
		smp_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(4))
			0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			1: return $signed(16'($urandom_range(600))) - 16'sd300;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_blocks(int items, bit mute_ok);
		int len, k;
		while (items > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 10, DEPTH)
				: $urandom_range(12, 1);
			for (k = 0; k < len && items > 0; k++) begin
				items--;
				send(rand_sample(), (k == len - 1) || items == 0,
					mute_ok && $urandom_range(7) == 0);
			end
		end
		drain();
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		cycles = 0;
		idle_pct = 38;
		hold_off = 0;
		hold_cycles = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		smp_valid = 0; smp_data = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, zero peak, mute, single-sample block, full store
		send(16'sh7fff, 0, 0);
		send(16'sh8000, 0, 0);
		send(16'sh0000, 1, 0);
		send(16'sh0000, 0, 0);
		send(16'sh0000, 1, 0);
		send(16'sh1234, 0, 1);
		send(-16'sd5, 1, 1);
		send(16'sd1, 1, 0);
		drain();
		for (int k = 0; k < DEPTH; k++) send(rand_sample(), 0, k == DEPTH - 1);
		drain();

		// fill the block up while the receiver holds off
		hold_off = 1;
		idle_pct = 0;
		random_blocks(80, 0);
		idle_pct = 38;

		// invalid settings, one at a time
		reg_write(REG_DC_ALPHA, 32769);
		send(16'sd100, 0, 0); send(-16'sd100, 1, 0);
		drain();
		reg_write(REG_DC_ALPHA, 32768);
		reg_write(REG_PEAK_TARGET, 0);
		send(16'sd77, 1, 0);
		drain();
		reg_write(REG_PEAK_TARGET, 32767);
		reg_write(REG_GAIN_FLOOR, 1000);
		reg_write(REG_GAIN_CEILING, 999);
		send(16'sd5, 1, 0);
		drain();

		// extreme settings
		reg_write(REG_GAIN_FLOOR, 0);
		reg_write(REG_GAIN_CEILING, 131071);
		reg_write(REG_ATTACK, 0);
		reg_write(REG_RELEASE, 15);
		random_blocks(60, 1);
		reg_write(REG_DC_ALPHA, 0);
		reg_write(REG_PEAK_TARGET, 1);
		reg_write(REG_GAIN_FLOOR, 131071);
		reg_write(REG_ATTACK, 15);
		reg_write(REG_RELEASE, 0);
		random_blocks(40, 1);

		// random settings, no idling for one stretch
		idle_pct = 0;
		reg_write(REG_DC_ALPHA, $urandom_range(32768));
		reg_write(REG_PEAK_TARGET, $urandom_range(32767, 1));
		reg_write(REG_GAIN_FLOOR, $urandom_range(40000));
		reg_write(REG_GAIN_CEILING, $urandom_range(131071, 40000));
		reg_write(REG_ATTACK, $urandom_range(15));
		reg_write(REG_RELEASE, $urandom_range(15));
		random_blocks(70, 1);
		idle_pct = 38;
		reg_write(REG_DC_ALPHA, 32604);
		reg_write(REG_PEAK_TARGET, 24000);
		reg_write(REG_GAIN_FLOOR, 8192);
		reg_write(REG_GAIN_CEILING, 65536);
		reg_write(REG_ATTACK, 1);
		reg_write(REG_RELEASE, 4);
		random_blocks(30, 1);

		drain();
		$display("covered %0d blocks, %0d output transfers, %0d cycles",
			sb.blocks, sb.checked, cycles);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS block_agc_dc_blocker_limiter");
		end else begin
			$display("%0d errors, %0d outputs missing", sb.errors, sb.pending.size());
			$display("FAIL block_agc_dc_blocker_limiter");
		end
		$finish;
	end

endmodule
